// ===== rtl/core/front_middle_rear_deque_unit_assert.svh =====
// Assertion macros used by the checker file of the deque unit.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef FRONT_MIDDLE_REAR_DEQUE_UNIT_ASSERT_SVH
`define FRONT_MIDDLE_REAR_DEQUE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FMRD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FMRD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/fmrd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fmrd_pkg;

	typedef enum logic [2:0] {
		CMD_ADD_FRONT  = 3'd0,
		CMD_ADD_REAR   = 3'd1,
		CMD_ADD_MIDDLE = 3'd2,
		CMD_DEL_FRONT  = 3'd3,
		CMD_DEL_REAR   = 3'd4,
		CMD_DEL_MIDDLE = 3'd5
	} fmrd_cmd_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} fmrd_status_t;

	typedef struct packed {
		logic [2:0]          command;
		logic signed [31:0]  value;
	} fmrd_req_t;

	typedef struct packed {
		logic [1:0]          status;
		logic signed [31:0]  removed_value;
		logic [5:0]          occupancy;
	} fmrd_rsp_t;

	// Decoded action for one item.
	typedef struct packed {
		logic        insert;
		logic        remove;
		logic [1:0]  status;
	} fmrd_op_t;

endpackage

`default_nettype wire

// ===== rtl/core/fmrd_plan.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fmrd_plan #(
	parameter int CAPACITY = 32
) (
	input  wire logic [$clog2(CAPACITY+1)-1:0] count,
	input  wire logic [2:0]                    command,
	output fmrd_pkg::fmrd_op_t                 op,
	output logic [$clog2(CAPACITY)-1:0]        pos
);
	import fmrd_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int POS_W = $clog2(CAPACITY);

	logic [CNT_W:0] count_inc;
	logic           full;
	logic           empty;

	assign count_inc = {1'b0, count} + {{CNT_W{1'b0}}, 1'b1};
	assign full      = (count == CNT_W'(CAPACITY));
	assign empty     = (count == '0);

	always_comb begin
		op  = '{insert: 1'b0, remove: 1'b0, status: ST_DONE};
		pos = '0;
		case (command)
			CMD_ADD_FRONT: begin
				op.insert = !full;
				op.status = full ? ST_FULL : ST_DONE;
			end
			CMD_ADD_REAR: begin
				op.insert = !full;
				op.status = full ? ST_FULL : ST_DONE;
				pos       = POS_W'(count);
			end
			CMD_ADD_MIDDLE: begin
				op.insert = !full;
				op.status = full ? ST_FULL : ST_DONE;
				pos       = POS_W'(count_inc >> 1);
			end
			CMD_DEL_FRONT: begin
				op.remove = !empty;
				op.status = empty ? ST_EMPTY : ST_DONE;
			end
			CMD_DEL_REAR: begin
				op.remove = !empty;
				op.status = empty ? ST_EMPTY : ST_DONE;
				pos       = POS_W'(count - {{(CNT_W-1){1'b0}}, 1'b1});
			end
			CMD_DEL_MIDDLE: begin
				op.remove = !empty;
				op.status = empty ? ST_EMPTY : ST_DONE;
				pos       = POS_W'(count >> 1);
			end
			default: begin
				// Unused codes leave the queue alone and report done.
				op = '{insert: 1'b0, remove: 1'b0, status: ST_DONE};
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/fmrd_cells.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fmrd_cells #(
	parameter int CAPACITY   = 32,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                        clk,
	input  wire logic                        en,
	input  wire fmrd_pkg::fmrd_op_t          op,
	input  wire logic [$clog2(CAPACITY)-1:0] pos,
	input  wire logic [DATA_WIDTH-1:0]       wdata,
	output logic [DATA_WIDTH-1:0]            rdata
);
	import fmrd_pkg::*;

	localparam int POS_W = $clog2(CAPACITY);

	logic [DATA_WIDTH-1:0] entries_q [CAPACITY];

	assign rdata = entries_q[pos];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam logic [POS_W-1:0] IDX = POS_W'(i);

		logic [DATA_WIDTH-1:0] below;
		logic [DATA_WIDTH-1:0] above;

		if (i == 0) begin : g_first
			assign below = wdata;
		end else begin : g_below
			assign below = entries_q[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign above = entries_q[i];
		end else begin : g_above
			assign above = entries_q[i+1];
		end

		// Each cell holds, loads the new word, or takes its neighbor's word.
		always_ff @(posedge clk) begin
			if (en && op.insert) begin
				if (IDX == pos) begin
					entries_q[i] <= wdata;
				end else if (IDX > pos) begin
					entries_q[i] <= below;
				end
			end else if (en && op.remove) begin
				if (IDX >= pos) begin
					entries_q[i] <= above;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/front_middle_rear_deque_unit.sv =====
// Front/middle/rear deque unit.
// The req channel carries one item per command: command selects add front,
// add rear, add middle, delete front, delete rear or delete middle, and value
// is the word to insert. The rsp channel returns exactly one item per request
// with the status, the removed word (zero unless a delete succeeded) and the
// occupancy after the command.
// An accepted request enters an input register; when it advances, the cell
// array shifts or loads in one pass and the response register is loaded.
// One item per cycle is sustained while rsp_stall stays low, because every
// cell chooses hold, shift or load in parallel.
// When rsp_stall is high and a response is waiting, that response holds its
// value; an item in the input register stays there and req_stall is high
// until the response is taken.
// Reset empties the queue and drops any item in flight. Stored words carry no
// reset; only positions below the occupancy are ever read.
`timescale 1ns / 1ps
`default_nettype none

module front_middle_rear_deque_unit #(
	parameter int CAPACITY   = 32,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire fmrd_pkg::fmrd_req_t req_item,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output fmrd_pkg::fmrd_rsp_t rsp_item
);
	import fmrd_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int POS_W = $clog2(CAPACITY);

	logic                   valid_s1;
	logic [2:0]             cmd_s1;
	logic signed [31:0]     value_s1;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       count_next;
	logic                   rsp_valid_q;
	fmrd_rsp_t              rsp_item_q;
	logic                   advance;
	fmrd_op_t               op;
	logic [POS_W-1:0]       pos;
	logic [DATA_WIDTH-1:0]  wdata;
	logic [DATA_WIDTH-1:0]  rdata;
	logic [31:0]            removed;

	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;
	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_item_q;

	fmrd_plan #(
		.CAPACITY (CAPACITY)
	) u_plan (
		.count   (count_q),
		.command (cmd_s1),
		.op      (op),
		.pos     (pos)
	);

	fmrd_cells #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_cells (
		.clk   (clk),
		.en    (advance),
		.op    (op),
		.pos   (pos),
		.wdata (wdata),
		.rdata (rdata)
	);

	// Words are stored sign-extended or truncated to the data width and come
	// back as 32 bits, sign-extended when the data width is below 32.
	if (DATA_WIDTH >= 32) begin : g_wide
		if (DATA_WIDTH > 32) begin : g_ext
			assign wdata = {{(DATA_WIDTH-32){value_s1[31]}}, value_s1};
		end else begin : g_same
			assign wdata = value_s1;
		end
		assign removed = rdata[31:0];
	end else begin : g_narrow
		assign wdata   = value_s1[DATA_WIDTH-1:0];
		assign removed = {{(32-DATA_WIDTH){rdata[DATA_WIDTH-1]}}, rdata};
	end

	always_comb begin
		count_next = count_q;
		if (op.insert) begin
			count_next = count_q + {{(CNT_W-1){1'b0}}, 1'b1};
		end else if (op.remove) begin
			count_next = count_q - {{(CNT_W-1){1'b0}}, 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_valid && !req_stall) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				count_q     <= count_next;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			cmd_s1   <= req_item.command;
			value_s1 <= req_item.value;
		end
		if (advance) begin
			rsp_item_q.status        <= op.status;
			rsp_item_q.removed_value <= op.remove ? removed : 32'd0;
			rsp_item_q.occupancy     <= 6'(count_next);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/fmrd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "front_middle_rear_deque_unit_assert.svh"

module fmrd_checker #(
	parameter int CAPACITY = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	input  wire logic          req_stall,
	input  wire fmrd_pkg::fmrd_req_t req_item,
	input  wire logic          rsp_valid,
	input  wire logic          rsp_stall,
	input  wire fmrd_pkg::fmrd_rsp_t rsp_item
);
	import fmrd_pkg::*;

	`FMRD_ASSERT_NEXT(a_req_hold, req_valid && req_stall, req_valid && $stable(req_item), "request changed while stalled")
	`FMRD_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_item), "response changed while stalled")
	`FMRD_ASSERT_SAME(a_full_count, rsp_valid && rsp_item.status == ST_FULL, rsp_item.occupancy == 6'(CAPACITY), "full rejection with queue not full")
	`FMRD_ASSERT_SAME(a_empty_zero, rsp_valid && rsp_item.status == ST_EMPTY, rsp_item.occupancy == 6'd0 && rsp_item.removed_value == 32'sd0, "empty rejection not clean")

endmodule

bind front_middle_rear_deque_unit fmrd_checker #(
	.CAPACITY (CAPACITY)
) u_fmrd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req_item  (req_item),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp_item  (rsp_item)
);

`default_nettype wire

// ===== tb/front_middle_rear_deque_unit_tb.sv =====
`timescale 1ns / 1ps

module front_middle_rear_deque_unit_tb;
	import fmrd_pkg::*;

	localparam int DEPTH          = 32;
	localparam int WORD_BITS      = 32;
	localparam int WORDS_PER_MODE = 150;
	localparam int DRAIN_CYCLES   = 8;
	localparam int CYCLE_LIMIT    = 200000;
	localparam int DIRECTED_COUNT = 20;

	// Command codes that the block decodes as no operation.
	localparam logic [2:0] CMD_SPARE_6 = 3'd6;
	localparam logic [2:0] CMD_SPARE_7 = 3'd7;

	typedef struct packed {
		logic [2:0]  command;
		logic [31:0] value;
		logic        known;
		logic [1:0]  status;
		logic [31:0] removed_value;
		logic [5:0]  occupancy;
	} directed_row_t;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	fmrd_req_t req_item;
	logic      rsp_valid;
	logic      rsp_stall;
	fmrd_rsp_t rsp_item;

	logic signed [31:0] held_words[$];
	fmrd_rsp_t          pending_rsp[$];
	fmrd_rsp_t          want_rsp;
	int                 send_idle_pct;
	int                 recv_idle_pct;
	int                 fail_count;
	int                 cycle_count;

	logic [2:0] add_cmds[3] = '{CMD_ADD_FRONT, CMD_ADD_REAR, CMD_ADD_MIDDLE};
	logic [2:0] del_cmds[3] = '{CMD_DEL_FRONT, CMD_DEL_REAR, CMD_DEL_MIDDLE};
	logic [2:0] any_cmds[8] = '{CMD_ADD_FRONT, CMD_ADD_REAR, CMD_ADD_MIDDLE, CMD_DEL_FRONT,
		CMD_DEL_REAR, CMD_DEL_MIDDLE, CMD_SPARE_6, CMD_SPARE_7};
	logic [31:0] edge_words[4] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff};

	// Rows marked known carry a result that follows directly from the sequence so far;
	// the others are checked against the predictor.
	directed_row_t directed_rows[DIRECTED_COUNT] = '{
		{CMD_DEL_FRONT,  32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000, 6'd0},
		{CMD_DEL_REAR,   32'hffff_ffff, 1'b1, ST_EMPTY, 32'h0000_0000, 6'd0},
		{CMD_DEL_MIDDLE, 32'h1234_5678, 1'b1, ST_EMPTY, 32'h0000_0000, 6'd0},
		{CMD_SPARE_6,    32'hffff_ffff, 1'b1, ST_DONE,  32'h0000_0000, 6'd0},
		{CMD_ADD_MIDDLE, 32'h7fff_ffff, 1'b1, ST_DONE,  32'h0000_0000, 6'd1},
		{CMD_ADD_MIDDLE, 32'h8000_0000, 1'b1, ST_DONE,  32'h0000_0000, 6'd2},
		{CMD_ADD_FRONT,  32'hffff_ffff, 1'b1, ST_DONE,  32'h0000_0000, 6'd3},
		{CMD_ADD_REAR,   32'h0000_0000, 1'b1, ST_DONE,  32'h0000_0000, 6'd4},
		{CMD_SPARE_7,    32'h5555_5555, 1'b1, ST_DONE,  32'h0000_0000, 6'd4},
		{CMD_DEL_MIDDLE, 32'h0000_0000, 1'b0, ST_DONE,  32'h0000_0000, 6'd0},
		{CMD_DEL_MIDDLE, 32'hffff_ffff, 1'b0, ST_DONE,  32'h0000_0000, 6'd0},
		{CMD_ADD_MIDDLE, 32'haaaa_aaaa, 1'b0, ST_DONE,  32'h0000_0000, 6'd0},
		{CMD_ADD_MIDDLE, 32'h1234_5678, 1'b0, ST_DONE,  32'h0000_0000, 6'd0},
		{CMD_DEL_FRONT,  32'h0000_0000, 1'b0, ST_DONE,  32'h0000_0000, 6'd0},
		{CMD_DEL_REAR,   32'h0000_0000, 1'b0, ST_DONE,  32'h0000_0000, 6'd0},
		{CMD_DEL_MIDDLE, 32'h0000_0000, 1'b0, ST_DONE,  32'h0000_0000, 6'd0},
		{CMD_DEL_MIDDLE, 32'h0000_0000, 1'b0, ST_DONE,  32'h0000_0000, 6'd0},
		{CMD_DEL_FRONT,  32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000, 6'd0},
		{CMD_ADD_REAR,   32'h0000_0001, 1'b1, ST_DONE,  32'h0000_0000, 6'd1},
		{CMD_DEL_REAR,   32'h0000_0000, 1'b1, ST_DONE,  32'h0000_0001, 6'd0}
	};

	front_middle_rear_deque_unit #(
		.CAPACITY  (DEPTH),
		.DATA_WIDTH(WORD_BITS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_item (req_item),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_item (rsp_item)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Applies one command to the queue copy and returns the response it should produce.
	function automatic fmrd_rsp_t apply_command(input fmrd_req_t item);
		fmrd_rsp_t   rsp;
		int unsigned count;
		int unsigned pos;
		rsp = '0;
		count = held_words.size();
		pos = 0;
		case (item.command)
			CMD_ADD_FRONT, CMD_ADD_REAR, CMD_ADD_MIDDLE: begin
				if (count >= DEPTH) begin
					rsp.status = ST_FULL;
				end else begin
					if (item.command == CMD_ADD_REAR)
						pos = count;
					else if (item.command == CMD_ADD_MIDDLE)
						pos = (count + 1) / 2;
					held_words.insert(pos, item.value);
				end
			end
			CMD_DEL_FRONT, CMD_DEL_REAR, CMD_DEL_MIDDLE: begin
				if (count == 0) begin
					rsp.status = ST_EMPTY;
				end else begin
					if (item.command == CMD_DEL_REAR)
						pos = count - 1;
					else if (item.command == CMD_DEL_MIDDLE)
						pos = count / 2;
					rsp.removed_value = held_words[pos];
					held_words.delete(pos);
				end
			end
			default: begin
			end
		endcase
		rsp.occupancy = 6'(held_words.size());
		return rsp;
	endfunction

	function automatic logic [31:0] pick_word();
		if ($urandom_range(7) == 0)
			return edge_words[$urandom_range(3)];
		return $urandom;
	endfunction

	// Entered and left at a falling edge; valid stays high when the next item follows at once.
	task automatic send_item(input fmrd_req_t item, input logic known, input fmrd_rsp_t typed);
		fmrd_rsp_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req_valid = 1'b1;
		req_item  = item;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		predicted = apply_command(item);
		pending_rsp.push_back(known ? typed : predicted);
		@(negedge clk);
	endtask

	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			rsp_stall = ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t: response with none expected: expected none actual %h", $time,
					rsp_item);
				fail_count++;
			end else begin
				want_rsp = pending_rsp.pop_front();
				if (rsp_item.status !== want_rsp.status) begin
					$display("%0t: status expected %0d actual %0d", $time, want_rsp.status,
						rsp_item.status);
					fail_count++;
				end
				if (rsp_item.removed_value !== want_rsp.removed_value) begin
					$display("%0t: removed_value expected %h actual %h", $time,
						want_rsp.removed_value, rsp_item.removed_value);
					fail_count++;
				end
				if (rsp_item.occupancy !== want_rsp.occupancy) begin
					$display("%0t: occupancy expected %0d actual %0d", $time,
						want_rsp.occupancy, rsp_item.occupancy);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** front_middle_rear_deque_unit: FAILED **");
			$finish;
		end
	end

	initial begin : stimulus
		fmrd_req_t item;
		fmrd_rsp_t typed;
		logic      filling;
		int        roll;
		arst_n        = 1'b0;
		req_valid     = 1'b0;
		req_item      = '0;
		fail_count    = 0;
		cycle_count   = 0;
		send_idle_pct = 16;
		recv_idle_pct = 53;
		filling       = 1'b1;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			item.command        = directed_rows[i].command;
			item.value          = directed_rows[i].value;
			typed.status        = directed_rows[i].status;
			typed.removed_value = directed_rows[i].removed_value;
			typed.occupancy     = directed_rows[i].occupancy;
			send_item(item, directed_rows[i].known, typed);
		end

		// Sweep between empty and full so that both rejections and deep middle
		// operations are exercised; a small share of items is any code at all.
		typed = '0;
		for (int mode = 0; mode < 3; mode++) begin
			send_idle_pct = (mode == 0) ? 16 : (mode == 1) ? 53 : 0;
			recv_idle_pct = (mode == 0) ? 53 : (mode == 1) ? 16 : 0;
			for (int n = 0; n < WORDS_PER_MODE; n++) begin
				if (filling && held_words.size() == DEPTH && $urandom_range(3) == 0)
					filling = 1'b0;
				else if (!filling && held_words.size() == 0 && $urandom_range(3) == 0)
					filling = 1'b1;
				roll = $urandom_range(99);
				if (roll < 5)
					item.command = any_cmds[$urandom_range(7)];
				else if ((roll < 85) == filling)
					item.command = add_cmds[$urandom_range(2)];
				else
					item.command = del_cmds[$urandom_range(2)];
				item.value = pick_word();
				send_item(item, 1'b0, typed);
			end
		end
		req_valid = 1'b0;

		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("** front_middle_rear_deque_unit: PASSED **");
		else
			$display("** front_middle_rear_deque_unit: FAILED **");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/fmrd_pkg.sv
rtl/core/fmrd_plan.sv
rtl/core/fmrd_cells.sv
rtl/core/front_middle_rear_deque_unit.sv
rtl/core/fmrd_checker.sv
tb/front_middle_rear_deque_unit_tb.sv
